### sv/auto_range_gain_controller_defines.svh
// Assertion macros shared by the auto-ranging gain controller RTL.
// Each macro expects aclk and aresetn in scope; no other dependencies.
`ifndef AUTO_RANGE_GAIN_CONTROLLER_DEFINES_SVH
`define AUTO_RANGE_GAIN_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define AGC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define AGC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/agc_pkg.sv
// Shared types and constants of the auto-ranging gain controller.
// No dependencies; imported by every module of the block.
package agc_pkg;

    // Samples seen before the two-back clamp takes effect.
    localparam int CLAMP_START = 20;
    localparam int SEEN_W      = $clog2(CLAMP_START + 2);

    // A sample at or above this value is out of range.
    localparam logic [15:0] ERR_LIMIT = 16'd33000;

    // Divide-by-five unit: one byte per step, reciprocal multiply.
    localparam int          DIV_W      = 40;
    localparam int          DIV_STEPS  = DIV_W / 8;
    localparam int          DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam logic [11:0] DIV5_RECIP = 12'd3277;
    localparam int          DIV5_SHIFT = 14;

    // Gain codes.
    localparam logic [1:0] IND_GAIN_10   = 2'd0;
    localparam logic [1:0] IND_GAIN_100  = 2'd1;
    localparam logic [1:0] IND_GAIN_1000 = 2'd2;
    localparam logic [1:0] IND_CODE_BAD  = 2'd3;
    localparam logic [1:0] RES_GAIN_1    = 2'd0;
    localparam logic [1:0] RES_GAIN_2    = 2'd1;
    localparam logic [1:0] RES_GAIN_5    = 2'd2;
    localparam logic [1:0] RES_GAIN_10   = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [23:0] K_RT_RST       = 24'd65536;
    localparam logic [31:0] TARGET_RST     = 32'd65536;
    localparam logic [15:0] SAT_THR_RST    = 16'd30000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_K_RT           = 3'd0,
        CFG_TARGET_CURRENT = 3'd1,
        CFG_SAT_THR_IND    = 3'd2,
        CFG_SAT_THR_RES    = 3'd3,
        CFG_START_GAIN_IND = 3'd4,
        CFG_START_GAIN_RES = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD_CUR,
        ST_DIV_CUR,
        ST_DIV_LIM
    } ctrl_state_t;

    // Input beat, last field in the lowest bits.
    typedef struct packed {
        logic [23:0] timer_value;
        logic [15:0] sample_res;
        logic [15:0] sample_ind;
    } agc_in_t;

    localparam int IN_W = $bits(agc_in_t);

    // Result beat, last field in the lowest bits.
    typedef struct packed {
        logic [23:0] reach_tick;
        logic        fet_on;
        logic        setting_error;
        logic        current_reached;
        logic        gain_ok;
        logic [31:0] current;
        logic [1:0]  gain_r_code;
        logic [1:0]  gain_l_code;
    } agc_out_t;

    localparam int OUT_W = $bits(agc_out_t);

    // Controller to datapath.
    typedef struct packed {
        logic load_in;   // capture the accepted input beat
        logic mul;       // form k_rt * sample_res
        logic load_cur;  // start dividing the product
        logic capt_cur;  // take the raw current, start dividing the limit
        logic commit;    // update state and write the result register
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic div_busy;
    } dp_sts_t;

endpackage

### sv/auto_range_gain_controller.sv
// Top level of the auto-ranging gain controller for a two-channel inductance meter.
// Depends on agc_pkg, agc_ctrl and agc_dp.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_tvalid / s_tready  s_tdata: sample_ind, sample_res, timer_value
//   m_        out        m_tvalid / m_tready  m_tdata: gains, current, flags, reach_tick
//   cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The shared divide-by-five unit runs twice per item (raw current, then the clamp limit)
// at one byte of 40 per cycle, and a new beat is accepted only once the last item commits.
// The result register parts the two sides: the next beat is accepted while a result
// still waits, and only the final commit stalls while the output is held by the sink.
// Reset (aresetn low at a rising edge) restores the configuration, the gain codes and
// all item state at once; the working data registers need no reset and there is no
// clearing pass. Configuration writes are always accepted.
module auto_range_gain_controller import agc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input beat, lowest bits first: sample_ind[15:0], sample_res[31:16],
    // timer_value[55:32].
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,
    // Result beat, lowest bits first: gain_l_code[1:0], gain_r_code[3:2],
    // current[35:4], gain_ok[36], current_reached[37], setting_error[38],
    // fet_on[39], reach_tick[63:40].
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    // Register writes: index 0 k_rt, 1 target_current, 2 sat_threshold_ind,
    // 3 sat_threshold_res, 4 start_gain_ind, 5 start_gain_res; others ignored.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // The register file takes a write in any cycle.
    assign cfg_ready = 1'b1;

    agc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the gain state and the result register.
    agc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .out_data  (m_tdata)
    );

endmodule

### sv/agc_div5.sv
// Divide-by-five unit, one byte of quotient per cycle, most significant first.
// Depends on agc_pkg for its width and reciprocal constants.
module agc_div5 import agc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  logic [DIV_W-1:0] dividend,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]     work_reg, work_next;
    logic [2:0]           rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;

    logic [10:0] part;
    logic [22:0] part_scaled;
    logic [7:0]  q_byte;
    logic [10:0] q_times5;
    logic [10:0] part_rem;

    // The partial dividend stays below 1280, where the reciprocal is exact.
    assign part        = {rem_reg, work_reg[DIV_W-1 -: 8]};
    assign part_scaled = 23'(part) * 23'(DIV5_RECIP);
    assign q_byte      = part_scaled[DIV5_SHIFT +: 8];
    assign q_times5    = {1'b0, q_byte, 2'b00} + {3'b000, q_byte};
    assign part_rem    = part - q_times5;

    always_comb begin
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (load) begin
            work_next = dividend;
            rem_next  = 3'd0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            work_next = {work_reg[DIV_W-9:0], q_byte};
            rem_next  = part_rem[2:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = work_reg;

endmodule

### sv/agc_dp.sv
// Datapath: configuration registers, multiplier, divider, clamp, gain rules.
// Depends on agc_pkg, agc_div5 and the assertion macro header.
`include "auto_range_gain_controller_defines.svh"

module agc_dp import agc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts,
    input  logic [IN_W-1:0]       in_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic [OUT_W-1:0]      out_data
);

    // Configuration.
    logic [23:0] k_rt_reg;
    logic [31:0] target_reg;
    logic [15:0] thr_ind_reg;
    logic [15:0] thr_res_reg;

    // Block state.
    logic [1:0]        ind_gain_reg, ind_gain_next;
    logic [1:0]        res_gain_reg, res_gain_next;
    logic [31:0]       hist0_reg, hist1_reg;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic              gain_ok_reg, gain_ok_next;
    logic              reached_reg, reached_next;
    logic              error_reg, error_next;
    logic [23:0]       held_tick_reg, held_tick_next;

    // Working registers.
    agc_in_t          in_reg;
    logic [DIV_W-1:0] prod_reg;
    logic [31:0]      cur_raw_reg;
    agc_out_t         out_reg;

    logic [DIV_W-1:0] mul_w;
    logic [DIV_W-1:0] prod_half;
    logic [DIV_W-1:0] div_din;
    logic             div_load;
    logic             div_busy;
    logic [DIV_W-1:0] div_q;
    logic [DIV_W-1:0] cur_sel;
    logic [31:0]      cur_sat;
    logic [35:0]      hist_x11;
    logic [31:0]      lim_sat;
    logic             clamp_on;
    logic [31:0]      cur_final;
    logic             fet;
    logic             in_range;
    logic             sat_ind;
    logic             sat_res;
    cfg_idx_t         cfg_sel;

    assign mul_w     = DIV_W'(k_rt_reg) * DIV_W'(in_reg.sample_res);
    assign prod_half = {1'b0, prod_reg[DIV_W-1:1]};

    // Gain 10 divides the halved product by five.
    assign div_load = cmd.load_cur || cmd.capt_cur;
    assign hist_x11 = {1'b0, hist0_reg, 3'b000} + {3'b000, hist0_reg, 1'b0}
                    + {4'b0000, hist0_reg};
    assign div_din  = cmd.capt_cur ? {5'b00000, hist_x11[35:1]}
                    : ((res_gain_reg == RES_GAIN_10) ? prod_half : prod_reg);

    agc_div5 u_div5 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (div_load),
        .dividend (div_din),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign sts.div_busy = div_busy;

    always_comb begin
        unique case (res_gain_reg)
            RES_GAIN_1:  cur_sel = prod_reg;
            RES_GAIN_2:  cur_sel = prod_half;
            RES_GAIN_5:  cur_sel = div_q;
            RES_GAIN_10: cur_sel = div_q;
            default:     cur_sel = div_q;
        endcase
    end

    assign cur_sat = (|cur_sel[DIV_W-1:32]) ? '1 : cur_sel[31:0];
    assign lim_sat = (|div_q[DIV_W-1:32]) ? '1 : div_q[31:0];

    // Sample counter saturates one past the clamp start.
    assign seen_next = (seen_reg < SEEN_W'(CLAMP_START + 1)) ? seen_reg + 1'b1 : seen_reg;
    assign clamp_on  = seen_next > SEEN_W'(CLAMP_START);
    assign cur_final = (clamp_on && (cur_raw_reg > lim_sat)) ? lim_sat : cur_raw_reg;

    assign in_range = (in_reg.sample_ind < ERR_LIMIT) && (in_reg.sample_res < ERR_LIMIT);
    assign sat_ind  = in_reg.sample_ind > thr_ind_reg;
    assign sat_res  = in_reg.sample_res > thr_res_reg;

    // Gain stepping: the inductor rule runs first and the resistor rule sees its result.
    always_comb begin
        ind_gain_next  = ind_gain_reg;
        res_gain_next  = res_gain_reg;
        gain_ok_next   = gain_ok_reg;
        reached_next   = reached_reg;
        error_next     = error_reg;
        held_tick_next = held_tick_reg;
        fet            = 1'b1;
        if (in_range) begin
            gain_ok_next = 1'b1;
            if (sat_ind) begin
                if (ind_gain_next != IND_GAIN_10) begin
                    ind_gain_next = IND_GAIN_10;
                    if ((res_gain_next == RES_GAIN_1) || (res_gain_next == RES_GAIN_5)) begin
                        res_gain_next = RES_GAIN_2;
                    end
                end
                gain_ok_next = 1'b0;
            end
            if (sat_res) begin
                priority if ((res_gain_next == RES_GAIN_5) || (res_gain_next == RES_GAIN_10)) begin
                    res_gain_next = RES_GAIN_2;
                end else if ((res_gain_next == RES_GAIN_2) && (ind_gain_next == IND_GAIN_1000)) begin
                    res_gain_next = RES_GAIN_1;
                end else begin
                    res_gain_next = res_gain_next;
                end
                gain_ok_next = 1'b0;
            end
            if (gain_ok_next && (cur_final >= target_reg)) begin
                held_tick_next = in_reg.timer_value;
                reached_next   = 1'b1;
                fet            = 1'b0;
            end
        end else begin
            error_next = 1'b1;
        end
    end

    assign cfg_sel = cfg_idx_t'(cfg_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_rt_reg      <= K_RT_RST;
            target_reg    <= TARGET_RST;
            thr_ind_reg   <= SAT_THR_RST;
            thr_res_reg   <= SAT_THR_RST;
            ind_gain_reg  <= IND_GAIN_1000;
            res_gain_reg  <= RES_GAIN_10;
            hist0_reg     <= '0;
            hist1_reg     <= '0;
            seen_reg      <= '0;
            gain_ok_reg   <= 1'b0;
            reached_reg   <= 1'b0;
            error_reg     <= 1'b0;
            held_tick_reg <= '0;
        end else begin
            if (cmd.commit) begin
                ind_gain_reg  <= ind_gain_next;
                res_gain_reg  <= res_gain_next;
                hist0_reg     <= hist1_reg;
                hist1_reg     <= cur_final;
                seen_reg      <= seen_next;
                gain_ok_reg   <= gain_ok_next;
                reached_reg   <= reached_next;
                error_reg     <= error_next;
                held_tick_reg <= held_tick_next;
            end
            if (cfg_we) begin
                unique case (cfg_sel)
                    CFG_K_RT:           k_rt_reg    <= cfg_wdata[23:0];
                    CFG_TARGET_CURRENT: target_reg  <= cfg_wdata;
                    CFG_SAT_THR_IND:    thr_ind_reg <= cfg_wdata[15:0];
                    CFG_SAT_THR_RES:    thr_res_reg <= cfg_wdata[15:0];
                    CFG_START_GAIN_IND: begin
                        // Code three has no meaning and is taken as gain 1000.
                        ind_gain_reg <= (cfg_wdata[1:0] == IND_CODE_BAD) ? IND_GAIN_1000
                                                                          : cfg_wdata[1:0];
                    end
                    CFG_START_GAIN_RES: res_gain_reg <= cfg_wdata[1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= agc_in_t'(in_data);
        end
        if (cmd.mul) begin
            prod_reg <= mul_w;
        end
        if (cmd.capt_cur) begin
            cur_raw_reg <= cur_sat;
        end
        if (cmd.commit) begin
            out_reg.gain_l_code     <= ind_gain_next;
            out_reg.gain_r_code     <= res_gain_next;
            out_reg.current         <= cur_final;
            out_reg.gain_ok         <= gain_ok_next;
            out_reg.current_reached <= reached_next;
            out_reg.setting_error   <= error_next;
            out_reg.fet_on          <= fet;
            out_reg.reach_tick      <= held_tick_next;
        end
    end

    assign out_data = out_reg;

    `AGC_ASSERT_NOW(a_ind_gain_legal, 1'b1, ind_gain_reg != IND_CODE_BAD, "inductor gain code three held")
    `AGC_ASSERT_NOW(a_seen_bound, 1'b1, seen_reg <= SEEN_W'(CLAMP_START + 1), "sample count past its limit")
    `AGC_ASSERT_NEXT(a_hist_shift, cmd.commit, hist0_reg == $past(hist1_reg), "current history did not shift")

endmodule

### sv/agc_ctrl.sv
// Controller state machine that sequences one item through the datapath.
// Depends on agc_pkg and the assertion macro header.
`include "auto_range_gain_controller_defines.svh"

module agc_ctrl import agc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic        out_busy;

    // The result register is free unless it holds a beat that is not taken now.
    assign out_busy = m_tvalid_reg && !m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:      state_next = ST_LOAD_CUR;
            ST_LOAD_CUR: state_next = ST_DIV_CUR;
            ST_DIV_CUR: begin
                if (!sts.div_busy) begin
                    state_next = ST_DIV_LIM;
                end
            end
            ST_DIV_LIM: begin
                if (!sts.div_busy && !out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_MUL:      cmd.mul      = 1'b1;
            ST_LOAD_CUR: cmd.load_cur = 1'b1;
            ST_DIV_CUR:  cmd.capt_cur = !sts.div_busy;
            ST_DIV_LIM:  cmd.commit   = !sts.div_busy && !out_busy;
            default: begin
            end
        endcase
    end

    assign m_tvalid_next = cmd.commit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `AGC_ASSERT_NOW(a_commit_free, cmd.commit, !out_busy, "result written over a waiting beat")
    `AGC_ASSERT_NOW(a_idle_div_quiet, state_reg == ST_IDLE, !sts.div_busy, "divider busy while idle")
    `AGC_ASSERT_NOW(a_valid_from_commit, $rose(m_tvalid_reg), $past(cmd.commit), "result valid without commit")

endmodule
